### hdl/upd_pkg.sv
// Shared types, character codes and hex decode helpers for the URL percent decoder.
package upd_pkg;

    localparam logic [7:0] C_PLUS  = 8'h2B;
    localparam logic [7:0] C_PCT   = 8'h25;
    localparam logic [7:0] C_SPACE = 8'h20;
    localparam logic [7:0] C_MINUS = 8'h2D;
    localparam logic [7:0] C_TAB   = 8'h09;
    localparam logic [7:0] C_CR    = 8'h0D;
    localparam logic [4:0] C_RADIX = 5'd16;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       in_last;
    } t_in;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    // One queue entry. split: emit '%' first, then data with last set.
    typedef struct packed {
        logic       split;
        logic [7:0] data;
        logic       last;
    } t_cmd;

    // Bit 4 flags a hex digit, bits 3:0 hold its value.
    function automatic logic [4:0] hex_digit(input logic [7:0] c);
        logic [4:0] r;
        r = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            r = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            r = {1'b1, 4'(c - 8'h57)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            r = {1'b1, 4'(c - 8'h37)};
        end
        return r;
    endfunction

    function automatic logic [7:0] plain_byte(input logic [7:0] c);
        return (c == C_PLUS) ? C_SPACE : c;
    endfunction

    function automatic logic [7:0] decode_pair(input logic [7:0] a, input logic [7:0] b);
        logic [4:0] va;
        logic [4:0] vb;
        logic       lead;
        logic [7:0] r;
        va   = hex_digit(a);
        vb   = hex_digit(b);
        lead = (a == C_SPACE) || (a >= C_TAB && a <= C_CR) || (a == C_PLUS) || (a == C_MINUS);
        r    = '0;
        if (va[4]) begin
            if (vb[4]) begin
                r = 8'({4'd0, va[3:0]} * C_RADIX) + {4'd0, vb[3:0]};
            end else begin
                r = {4'd0, va[3:0]};
            end
        end else if (lead && vb[4]) begin
            if (a == C_MINUS) begin
                r = 8'd0 - {4'd0, vb[3:0]};
            end else begin
                r = {4'd0, vb[3:0]};
            end
        end
        return r;
    endfunction

endpackage

### hdl/upd_front.sv
// Front end: accepts input beats, tracks escape state, pushes decode commands.
module upd_front (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_valid,
    output logic         o_in_ready,
    input  upd_pkg::t_in i_in_item,
    input  logic         i_q_full,
    output logic         o_push,
    output upd_pkg::t_cmd o_cmd
);
    import upd_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_PCT,
        PH_HELD
    } t_phase;

    t_phase     r_phase, n_phase;
    logic [7:0] r_held, n_held;
    logic       accept;
    logic       n_push;
    t_cmd       n_cmd;

    assign o_in_ready = !i_q_full;
    assign accept     = i_in_valid && !i_q_full;

    always_comb begin
        n_phase = r_phase;
        n_held  = r_held;
        n_push  = 1'b0;
        n_cmd   = '{split: 1'b0, data: plain_byte(i_in_item.in_byte),
                    last: i_in_item.in_last};
        case (r_phase)
            PH_PCT: begin
                if (i_in_item.in_last) begin
                    n_push     = 1'b1;
                    n_cmd.split = 1'b1;
                    n_phase    = PH_IDLE;
                end else begin
                    n_held  = i_in_item.in_byte;
                    n_phase = PH_HELD;
                end
            end
            PH_HELD: begin
                n_push     = 1'b1;
                n_cmd.data = decode_pair(r_held, i_in_item.in_byte);
                n_phase    = PH_IDLE;
            end
            default: begin
                if (i_in_item.in_byte == C_PCT) begin
                    if (i_in_item.in_last) begin
                        n_push     = 1'b1;
                        n_cmd.data = C_PCT;
                        n_phase    = PH_IDLE;
                    end else begin
                        n_phase = PH_PCT;
                    end
                end else begin
                    n_push  = 1'b1;
                    n_phase = PH_IDLE;
                end
            end
        endcase
    end

    assign o_push = accept && n_push;
    assign o_cmd  = n_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_held  <= '0;
        end else if (accept) begin
            r_phase <= n_phase;
            r_held  <= n_held;
        end
    end

endmodule

### hdl/upd_queue.sv
// Small register FIFO of decode commands between front and back end.
module upd_queue #(
    parameter int DEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  upd_pkg::t_cmd i_data,
    output logic          o_full,
    input  logic          i_pop,
    output logic          o_empty,
    output upd_pkg::t_cmd o_data
);
    import upd_pkg::*;

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr_ptr, r_rd_ptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

### hdl/upd_back.sv
// Back end: drains commands into the output register, splitting two-beat commands.
module upd_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_q_empty,
    input  upd_pkg::t_cmd i_q_data,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output upd_pkg::t_out o_out_item
);
    import upd_pkg::*;

    logic       r_out_valid;
    t_out       r_out;
    logic       r_pend;
    logic [7:0] r_pend_byte;
    logic       load;

    assign load        = !r_out_valid || i_out_ready;
    assign o_pop       = load && !r_pend && !i_q_empty;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else if (load) begin
            if (r_pend) begin
                r_out_valid <= 1'b1;
                r_pend      <= 1'b0;
            end else if (!i_q_empty) begin
                r_out_valid <= 1'b1;
                r_pend      <= i_q_data.split;
            end else begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload: no reset needed
    always_ff @(posedge i_clk) begin
        if (load) begin
            if (r_pend) begin
                r_out <= '{out_byte: r_pend_byte, out_last: 1'b1};
            end else if (i_q_data.split) begin
                r_out       <= '{out_byte: C_PCT, out_last: 1'b0};
                r_pend_byte <= i_q_data.data;
            end else begin
                r_out <= '{out_byte: i_q_data.data, out_last: i_q_data.last};
            end
        end
    end

endmodule

### hdl/url_percent_decoder_top.sv
// A beat that yields output goes through the queue and output register to o_out_valid.
// Throughput: one input beat per cycle while o_in_ready is high; a truncated escape
// yields two output beats; no pop while the second is sent, so o_in_ready can drop.
// o_in_ready drops only when the command queue is full.
// Reset: synchronous, active low; clears escape state, queue pointers and output valid.
module url_percent_decoder_top #(
    parameter int QDEPTH = 2
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  upd_pkg::t_in  i_in_item,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output upd_pkg::t_out o_out_item
);
    import upd_pkg::*;

    logic q_full, q_empty, q_push, q_pop;
    t_cmd push_cmd, head_cmd;

    upd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_item  (i_in_item),
        .i_q_full   (q_full),
        .o_push     (q_push),
        .o_cmd      (push_cmd)
    );

    upd_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (push_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_data  (head_cmd)
    );

    upd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_empty   (q_empty),
        .i_q_data    (head_cmd),
        .o_pop       (q_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item)
    );

endmodule

### hdl/upd_checker.sv
// Port-level checker for the URL percent decoder, bound to the top level.
module upd_checker (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_in_valid,
    input logic          o_in_ready,
    input upd_pkg::t_in  i_in_item,
    input logic          o_out_valid,
    input logic          i_out_ready,
    input upd_pkg::t_out o_out_item
);
    import upd_pkg::*;

    // texts whose final input beat is in but whose final output beat is not yet out
    logic [7:0] r_open;
    logic       in_end, out_end;

    assign in_end  = i_in_valid && o_in_ready && i_in_item.in_last;
    assign out_end = o_out_valid && i_out_ready && o_out_item.out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= '0;
        end else if (in_end && !out_end) begin
            r_open <= r_open + 1'b1;
        end else if (!in_end && out_end) begin
            r_open <= r_open - 1'b1;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_item))
        else $error("output beat changed while stalled");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_last_matched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_out_item.out_last |-> r_open != 8'd0)
        else $error("final output beat without a final input beat");

    a_no_ready_drop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> o_out_valid)
        else $error("input stalled while output side empty");

endmodule

bind url_percent_decoder_top upd_checker u_upd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_item   (i_in_item),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_item  (o_out_item)
);
